// File: hw/rtl/hsra_pkg.sv
// Shared types and constants for the halo sub-block row address generator.
// No dependencies; every other file in hw/rtl uses this package.
package hsra_pkg;

    // Field widths
    localparam int CMD_W    = 1;
    localparam int ID_W     = 5;
    localparam int ROW_W    = 10;
    localparam int HALO_W   = 5;
    localparam int MID_W    = 11;
    localparam int VPP_W    = 5;
    localparam int OFF_W    = 35;
    localparam int LEN_W    = 15;
    localparam int STATUS_W = 2;

    // Axis values (lengths, starts, padded sizes) do not exceed 2*31 + 2047
    localparam int AX_W = MID_W + 2;
    // Product of two axis values plus one carry bit
    localparam int PW   = 2 * AX_W + 1;

    // Configuration port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam logic [2:0] REG_HALO_WIDTH = 3'd0;
    localparam logic [2:0] REG_MID_LEN_X  = 3'd1;
    localparam logic [2:0] REG_MID_LEN_Y  = 3'd2;
    localparam logic [2:0] REG_MID_LEN_Z  = 3'd3;
    localparam logic [2:0] REG_VPP        = 3'd4;

    // Sub-block ids
    localparam logic [ID_W-1:0] CENTRE_ID = 5'd13;
    localparam logic [ID_W-1:0] NUM_SUB   = 5'd27;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CENTRE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PACK   = 1'b0;
    localparam logic [CMD_W-1:0] CMD_UNPACK = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [ID_W-1:0]  sub_block;
        logic [ROW_W-1:0] row_y;
        logic [ROW_W-1:0] slab_z;
    } req_word_t;

    typedef struct packed {
        logic [OFF_W-1:0]    src_offset;
        logic [OFF_W-1:0]    dst_offset;
        logic [LEN_W-1:0]    row_len;
        logic [STATUS_W-1:0] status;
    } rsp_word_t;

    typedef struct packed {
        logic [HALO_W-1:0] halo_width;
        logic [MID_W-1:0]  mid_len_x;
        logic [MID_W-1:0]  mid_len_y;
        logic [MID_W-1:0]  mid_len_z;
        logic [VPP_W-1:0]  values_per_point;
    } cfg_t;

    // After decode: sub-block geometry
    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [STATUS_W-1:0] status;
        logic                past_centre;
        logic [AX_W-1:0]     sx;
        logic [AX_W-1:0]     sy;
        logic [AX_W-1:0]     sz;
        logic [AX_W-1:0]     xlen;
        logic [AX_W-1:0]     ly;
        logic [AX_W-1:0]     lz;
        logic [AX_W-1:0]     px;
        logic [AX_W-1:0]     py;
        logic [ROW_W-1:0]    row_y;
        logic [ROW_W-1:0]    slab_z;
    } geo_t;

    // After first product stage
    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [STATUS_W-1:0] status;
        logic                past_centre;
        logic [AX_W-1:0]     sx;
        logic [AX_W-1:0]     sz;
        logic [AX_W-1:0]     px;
        logic [AX_W-1:0]     lz;
        logic [AX_W-1:0]     xlen;
        logic [ROW_W-1:0]    row_y;
        logic [AX_W:0]       sy_y;
        logic [PW-1:0]       m_pyz;
        logic [PW-1:0]       m_pxy;
        logic [PW-1:0]       m_sypx;
        logic [PW-1:0]       m_lysx;
        logic [PW-1:0]       m_zly;
        logic [PW-1:0]       m_mxy;
        logic [LEN_W-1:0]    row_len;
    } prod_t;

    // After second product stage: terms per point, modulo the offset width
    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [STATUS_W-1:0] status;
        logic [AX_W-1:0]     sx;
        logic [OFF_W-1:0]    f_row;
        logic [OFF_W-1:0]    b_slab;
        logic [OFF_W-1:0]    b_rowbase;
        logic [OFF_W-1:0]    b_row;
        logic [OFF_W-1:0]    b_centre;
        logic [LEN_W-1:0]    row_len;
    } term_t;

    // Offsets in points, before scaling by values per point
    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [STATUS_W-1:0] status;
        logic [OFF_W-1:0]    flat_pt;
        logic [OFF_W-1:0]    buf_pt;
        logic [LEN_W-1:0]    row_len;
    } pt_t;

endpackage

// File: hw/rtl/hsra_cfg.sv
// Configuration register file behind an APB-style port, with write saturation.
// Depends on hsra_pkg.
module hsra_cfg #(
    parameter int MAX_MID_LEN          = 1024,
    parameter int MAX_HALO             = 16,
    parameter int MAX_VALUES_PER_POINT = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hsra_pkg::PADDR_W-1:0]   paddr,
    input  logic [hsra_pkg::PDATA_W-1:0]   pwdata,
    output logic [hsra_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output hsra_pkg::cfg_t                 cfg
);

    localparam int HW = hsra_pkg::HALO_W;
    localparam int MW = hsra_pkg::MID_W;
    localparam int VW = hsra_pkg::VPP_W;
    localparam int DW = hsra_pkg::PDATA_W;

    hsra_pkg::cfg_t cfg_reg;
    hsra_pkg::cfg_t cfg_next;
    logic [2:0]     reg_idx;
    logic           wr_en;
    logic [HW-1:0]  halo_sat;
    logic [MW-1:0]  mid_sat;
    logic [VW-1:0]  vpp_sat;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // Saturate written values to their bounds
    always_comb
    begin
        halo_sat = pwdata[HW-1:0];
        if ({{(DW-HW){1'b0}}, pwdata[HW-1:0]} > DW'(MAX_HALO))
        begin
            halo_sat = HW'(MAX_HALO);
        end
        mid_sat = pwdata[MW-1:0];
        if ({{(DW-MW){1'b0}}, pwdata[MW-1:0]} > DW'(MAX_MID_LEN))
        begin
            mid_sat = MW'(MAX_MID_LEN);
        end
        vpp_sat = pwdata[VW-1:0];
        if ({{(DW-VW){1'b0}}, pwdata[VW-1:0]} > DW'(MAX_VALUES_PER_POINT))
        begin
            vpp_sat = VW'(MAX_VALUES_PER_POINT);
        end
    end

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                hsra_pkg::REG_HALO_WIDTH: cfg_next.halo_width       = halo_sat;
                hsra_pkg::REG_MID_LEN_X:  cfg_next.mid_len_x        = mid_sat;
                hsra_pkg::REG_MID_LEN_Y:  cfg_next.mid_len_y        = mid_sat;
                hsra_pkg::REG_MID_LEN_Z:  cfg_next.mid_len_z        = mid_sat;
                hsra_pkg::REG_VPP:        cfg_next.values_per_point = vpp_sat;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.halo_width       <= HW'(1);
            cfg_reg.mid_len_x        <= MW'(1);
            cfg_reg.mid_len_y        <= MW'(1);
            cfg_reg.mid_len_z        <= MW'(1);
            cfg_reg.values_per_point <= VW'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_idx)
            hsra_pkg::REG_HALO_WIDTH: prdata = DW'(cfg_reg.halo_width);
            hsra_pkg::REG_MID_LEN_X:  prdata = DW'(cfg_reg.mid_len_x);
            hsra_pkg::REG_MID_LEN_Y:  prdata = DW'(cfg_reg.mid_len_y);
            hsra_pkg::REG_MID_LEN_Z:  prdata = DW'(cfg_reg.mid_len_z);
            hsra_pkg::REG_VPP:        prdata = DW'(cfg_reg.values_per_point);
            default:                  prdata = '0;
        endcase
    end

endmodule

// File: hw/rtl/hsra_decode.sv
// Input register and sub-block decode stage: coordinates, axis lengths and
// starts, padded sizes and status. Depends on hsra_pkg.
module hsra_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  hsra_pkg::cfg_t      cfg,
    input  logic                in_valid,
    input  hsra_pkg::req_word_t in_word,
    output logic                in_ready,
    output logic                out_valid,
    output hsra_pkg::geo_t      out_geo,
    input  logic                out_ready
);

    localparam int AW = hsra_pkg::AX_W;
    localparam int IW = hsra_pkg::ID_W;
    localparam int RW = hsra_pkg::ROW_W;

    hsra_pkg::req_word_t req_reg;
    logic                req_v_reg;
    hsra_pkg::geo_t      geo_reg;
    hsra_pkg::geo_t      geo_next;
    logic                geo_v_reg;
    logic                en_req;
    logic                en_geo;

    logic [IW-1:0] id;
    logic [IW-1:0] r9;
    logic [IW-1:0] r3;
    logic [1:0]    cx;
    logic [1:0]    cy;
    logic [1:0]    cz;
    logic [AW-1:0] hx;
    logic [AW-1:0] mx;
    logic [AW-1:0] my;
    logic [AW-1:0] mz;

    // Edge parts hold the halo, the middle part the mid length
    function automatic logic [AW-1:0] axis_len(input logic [1:0] c,
                                               input logic [AW-1:0] h,
                                               input logic [AW-1:0] mid);
        axis_len = (c == 2'd1) ? mid : h;
    endfunction

    // Start of a part along an axis; also the summed length of the parts below it
    function automatic logic [AW-1:0] axis_start(input logic [1:0] c,
                                                 input logic [AW-1:0] h,
                                                 input logic [AW-1:0] mid);
        case (c)
            2'd0:    axis_start = '0;
            2'd1:    axis_start = h;
            default: axis_start = h + mid;
        endcase
    endfunction

    assign en_geo   = !geo_v_reg || out_ready;
    assign en_req   = !req_v_reg || en_geo;
    assign in_ready = en_req;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_v_reg <= 1'b0;
        end
        else if (en_req)
        begin
            req_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_req)
        begin
            req_reg <= in_word;
        end
    end

    // Split id into x + 3y + 9z
    assign id = req_reg.sub_block;
    always_comb
    begin
        if (id >= IW'(18))
        begin
            cz = 2'd2;
            r9 = id - IW'(18);
        end
        else if (id >= IW'(9))
        begin
            cz = 2'd1;
            r9 = id - IW'(9);
        end
        else
        begin
            cz = 2'd0;
            r9 = id;
        end
        if (r9 >= IW'(6))
        begin
            cy = 2'd2;
            r3 = r9 - IW'(6);
        end
        else if (r9 >= IW'(3))
        begin
            cy = 2'd1;
            r3 = r9 - IW'(3);
        end
        else
        begin
            cy = 2'd0;
            r3 = r9;
        end
        cx = r3[1:0];
    end

    assign hx = AW'(cfg.halo_width);
    assign mx = AW'(cfg.mid_len_x);
    assign my = AW'(cfg.mid_len_y);
    assign mz = AW'(cfg.mid_len_z);

    // Geometry and status
    always_comb
    begin
        geo_next.cmd         = req_reg.cmd;
        geo_next.past_centre = id > hsra_pkg::CENTRE_ID;
        geo_next.sx          = axis_start(cx, hx, mx);
        geo_next.sy          = axis_start(cy, hx, my);
        geo_next.sz          = axis_start(cz, hx, mz);
        geo_next.xlen        = axis_len(cx, hx, mx);
        geo_next.ly          = axis_len(cy, hx, my);
        geo_next.lz          = axis_len(cz, hx, mz);
        geo_next.px          = (hx << 1) + mx;
        geo_next.py          = (hx << 1) + my;
        geo_next.row_y       = req_reg.row_y;
        geo_next.slab_z      = req_reg.slab_z;
        if (id == hsra_pkg::CENTRE_ID)
        begin
            geo_next.status = hsra_pkg::ST_CENTRE;
        end
        else if (id >= hsra_pkg::NUM_SUB)
        begin
            geo_next.status = hsra_pkg::ST_RANGE;
        end
        else if (({{(AW-RW){1'b0}}, req_reg.row_y} >= geo_next.ly) ||
                 ({{(AW-RW){1'b0}}, req_reg.slab_z} >= geo_next.lz))
        begin
            geo_next.status = hsra_pkg::ST_RANGE;
        end
        else
        begin
            geo_next.status = hsra_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geo_v_reg <= 1'b0;
        end
        else if (en_geo)
        begin
            geo_v_reg <= req_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_geo)
        begin
            geo_reg <= geo_next;
        end
    end

    assign out_valid = geo_v_reg;
    assign out_geo   = geo_reg;

endmodule

// File: hw/rtl/hsra_mult.sv
// Two product stages: axis products, then the per-point offset terms
// reduced modulo the offset width. Depends on hsra_pkg.
module hsra_mult (
    input  logic           clk,
    input  logic           rst_n,
    input  hsra_pkg::cfg_t cfg,
    input  logic           in_valid,
    input  hsra_pkg::geo_t in_geo,
    output logic           in_ready,
    output logic           out_valid,
    output hsra_pkg::term_t out_term,
    input  logic           out_ready
);

    localparam int AW = hsra_pkg::AX_W;
    localparam int P  = hsra_pkg::PW;
    localparam int OW = hsra_pkg::OFF_W;
    localparam int LW = hsra_pkg::LEN_W;
    localparam int VW = hsra_pkg::VPP_W;
    localparam int MW = hsra_pkg::MID_W;

    hsra_pkg::prod_t prod_reg;
    hsra_pkg::prod_t prod_next;
    logic            prod_v_reg;
    hsra_pkg::term_t term_reg;
    hsra_pkg::term_t term_next;
    logic            term_v_reg;
    logic            en_prod;
    logic            en_term;

    logic [AW:0]      sz_z;
    logic [AW+VW-1:0] len_full;

    logic [P:0]       a_row;
    logic [P:0]       a_rowbase;
    logic [P:0]       a_row_b;
    logic [AW+P:0]    f_row_full;
    logic [AW+P:0]    b_slab_full;
    logic [AW+P:0]    b_rowbase_full;
    logic [AW+P:0]    b_row_full;
    logic [MW+P-1:0]  b_centre_full;

    assign en_term  = !term_v_reg || out_ready;
    assign en_prod  = !prod_v_reg || en_term;
    assign in_ready = en_prod;

    // Axis products
    assign sz_z     = (AW+1)'(in_geo.sz) + (AW+1)'(in_geo.slab_z);
    assign len_full = in_geo.xlen * cfg.values_per_point;

    always_comb
    begin
        prod_next.cmd         = in_geo.cmd;
        prod_next.status      = in_geo.status;
        prod_next.past_centre = in_geo.past_centre;
        prod_next.sx          = in_geo.sx;
        prod_next.sz          = in_geo.sz;
        prod_next.px          = in_geo.px;
        prod_next.lz          = in_geo.lz;
        prod_next.xlen        = in_geo.xlen;
        prod_next.row_y       = in_geo.row_y;
        prod_next.sy_y        = (AW+1)'(in_geo.sy) + (AW+1)'(in_geo.row_y);
        prod_next.m_pyz       = P'(in_geo.py * sz_z);
        prod_next.m_pxy       = P'(in_geo.px * in_geo.py);
        prod_next.m_sypx      = P'(in_geo.sy * in_geo.px);
        prod_next.m_lysx      = P'(in_geo.ly * in_geo.sx);
        prod_next.m_zly       = P'(in_geo.slab_z * in_geo.ly);
        prod_next.m_mxy       = P'(cfg.mid_len_x * cfg.mid_len_y);
        prod_next.row_len     = len_full[LW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg <= 1'b0;
        end
        else if (en_prod)
        begin
            prod_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_prod)
        begin
            prod_reg <= prod_next;
        end
    end

    // Flat: px*(sy + y + py*(sz + z)); buffer: px*py*sz + lz*(sy*px + ly*sx)
    // + (z*ly + y)*xlen, less the centre block when the id lies past it
    assign a_row          = (P+1)'(prod_reg.sy_y) + (P+1)'(prod_reg.m_pyz);
    assign a_rowbase      = (P+1)'(prod_reg.m_sypx) + (P+1)'(prod_reg.m_lysx);
    assign a_row_b        = (P+1)'(prod_reg.m_zly) + (P+1)'(prod_reg.row_y);
    assign f_row_full     = prod_reg.px * a_row;
    assign b_slab_full    = prod_reg.m_pxy * prod_reg.sz;
    assign b_rowbase_full = prod_reg.lz * a_rowbase;
    assign b_row_full     = a_row_b * prod_reg.xlen;
    assign b_centre_full  = prod_reg.m_mxy * cfg.mid_len_z;

    always_comb
    begin
        term_next.cmd       = prod_reg.cmd;
        term_next.status    = prod_reg.status;
        term_next.sx        = prod_reg.sx;
        term_next.f_row     = f_row_full[OW-1:0];
        term_next.b_slab    = b_slab_full[OW-1:0];
        term_next.b_rowbase = b_rowbase_full[OW-1:0];
        term_next.b_row     = b_row_full[OW-1:0];
        term_next.b_centre  = prod_reg.past_centre ? OW'(b_centre_full) : '0;
        term_next.row_len   = prod_reg.row_len;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_v_reg <= 1'b0;
        end
        else if (en_term)
        begin
            term_v_reg <= prod_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_term)
        begin
            term_reg <= term_next;
        end
    end

    assign out_valid = term_v_reg;
    assign out_term  = term_reg;

endmodule

// File: hw/rtl/hsra_final.sv
// Sum stage, then scaling by values per point, direction select and the
// output register. Depends on hsra_pkg.
module hsra_final (
    input  logic                clk,
    input  logic                rst_n,
    input  hsra_pkg::cfg_t      cfg,
    input  logic                in_valid,
    input  hsra_pkg::term_t     in_term,
    output logic                in_ready,
    output logic                out_valid,
    output hsra_pkg::rsp_word_t out_word,
    input  logic                out_ready
);

    localparam int OW = hsra_pkg::OFF_W;
    localparam int VW = hsra_pkg::VPP_W;

    hsra_pkg::pt_t       pt_reg;
    hsra_pkg::pt_t       pt_next;
    logic                pt_v_reg;
    hsra_pkg::rsp_word_t rsp_reg;
    hsra_pkg::rsp_word_t rsp_next;
    logic                rsp_v_reg;
    logic                en_pt;
    logic                en_rsp;

    logic [OW+VW-1:0] flat_full;
    logic [OW+VW-1:0] buf_full;

    assign en_rsp   = !rsp_v_reg || out_ready;
    assign en_pt    = !pt_v_reg || en_rsp;
    assign in_ready = en_pt;

    // Offsets in points
    always_comb
    begin
        pt_next.cmd     = in_term.cmd;
        pt_next.status  = in_term.status;
        pt_next.flat_pt = OW'(in_term.sx) + in_term.f_row;
        pt_next.buf_pt  = in_term.b_slab + in_term.b_rowbase + in_term.b_row
                          - in_term.b_centre;
        pt_next.row_len = in_term.row_len;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_v_reg <= 1'b0;
        end
        else if (en_pt)
        begin
            pt_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_pt)
        begin
            pt_reg <= pt_next;
        end
    end

    // Scale to elements, pick direction, clear flagged words
    assign flat_full = pt_reg.flat_pt * cfg.values_per_point;
    assign buf_full  = pt_reg.buf_pt * cfg.values_per_point;

    always_comb
    begin
        rsp_next.status = pt_reg.status;
        if (pt_reg.status != hsra_pkg::ST_OK)
        begin
            rsp_next.src_offset = '0;
            rsp_next.dst_offset = '0;
            rsp_next.row_len    = '0;
        end
        else if (pt_reg.cmd == hsra_pkg::CMD_UNPACK)
        begin
            rsp_next.src_offset = buf_full[OW-1:0];
            rsp_next.dst_offset = flat_full[OW-1:0];
            rsp_next.row_len    = pt_reg.row_len;
        end
        else
        begin
            rsp_next.src_offset = flat_full[OW-1:0];
            rsp_next.dst_offset = buf_full[OW-1:0];
            rsp_next.row_len    = pt_reg.row_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_v_reg <= 1'b0;
        end
        else if (en_rsp)
        begin
            rsp_v_reg <= pt_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_rsp)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign out_valid = rsp_v_reg;
    assign out_word  = rsp_reg;

endmodule

// File: hw/rtl/halo_subblock_row_address_generator.sv
// Top level of the halo sub-block row address generator: APB register file
// and a six-stage address pipeline. Depends on hsra_pkg and the hsra_* modules.
//
//   channel  direction  handshake          word
//   req      in         req_valid/stall    cmd, sub_block, row_y, slab_z
//   rsp      out        rsp_valid/stall    src_offset, dst_offset, row_len, status
//   cfg      in         APB psel/penable   five registers at byte address 4*i
//
// One word per cycle while rsp_stall is low; an accepted word passes through the
// input register, decode, two product stages, sum and scale/output register.
// Each stage holds its own valid bit and advances when the next one is empty
// or advancing, so bubbles close up under rsp_stall and nothing is dropped.
// Reset clears the valid bits and sets every configuration register to 1; no clearing pass.
module halo_subblock_row_address_generator #(
    parameter int MAX_MID_LEN          = 1024,
    parameter int MAX_HALO             = 16,
    parameter int MAX_VALUES_PER_POINT = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  hsra_pkg::req_word_t          req_word,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output hsra_pkg::rsp_word_t          rsp_word,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hsra_pkg::PADDR_W-1:0] paddr,
    input  logic [hsra_pkg::PDATA_W-1:0] pwdata,
    output logic [hsra_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    hsra_pkg::cfg_t  cfg;
    hsra_pkg::geo_t  geo;
    hsra_pkg::term_t term;
    logic            req_ready;
    logic            geo_valid;
    logic            geo_ready;
    logic            term_valid;
    logic            term_ready;

    hsra_cfg #(
        .MAX_MID_LEN         (MAX_MID_LEN),
        .MAX_HALO            (MAX_HALO),
        .MAX_VALUES_PER_POINT(MAX_VALUES_PER_POINT)
    ) u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .cfg    (cfg)
    );

    hsra_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (req_valid),
        .in_word  (req_word),
        .in_ready (req_ready),
        .out_valid(geo_valid),
        .out_geo  (geo),
        .out_ready(geo_ready)
    );

    hsra_mult u_mult (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (geo_valid),
        .in_geo   (geo),
        .in_ready (geo_ready),
        .out_valid(term_valid),
        .out_term (term),
        .out_ready(term_ready)
    );

    hsra_final u_final (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (term_valid),
        .in_term  (term),
        .in_ready (term_ready),
        .out_valid(rsp_valid),
        .out_word (rsp_word),
        .out_ready(!rsp_stall)
    );

    assign req_stall = !req_ready;

`ifndef NO_ASSERTIONS
    // An empty output register frees the whole pipeline
    a_free_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> !req_stall)
        else $error("req stalled with an empty output register");

    // A word accepted while the output keeps flowing reaches the output register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(rst_n && req_valid && !req_stall, 6) &&
         $past(rst_n && !rsp_stall, 5) && $past(rst_n && !rsp_stall, 4) &&
         $past(rst_n && !rsp_stall, 3) && $past(rst_n && !rsp_stall, 2) &&
         $past(rst_n && !rsp_stall, 1)) |-> rsp_valid)
        else $error("accepted word did not reach the output in six cycles");

    // Flagged words carry no addresses or length
    a_flag_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_word.status != hsra_pkg::ST_OK) |->
        (rsp_word.src_offset == '0 && rsp_word.dst_offset == '0 &&
         rsp_word.row_len == '0))
        else $error("flagged word with nonzero offsets or length");
`endif

endmodule
